// ===== rtl/core/rolling_average_air_quality_index_defines.svh =====
// Assertion macros shared by the rolling average air quality index modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ROLLING_AVERAGE_AIR_QUALITY_INDEX_DEFINES_SVH
`define ROLLING_AVERAGE_AIR_QUALITY_INDEX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RAQI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAQI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/raqi_pkg.sv =====
// Shared types, constants and breakpoint table for the air quality index block.
// No dependencies; the modules refer to it by scoped names.
package raqi_pkg;

	localparam int WINDOW_SLOTS = 1024;
	localparam int SLOT_W = $clog2(WINDOW_SLOTS);
	localparam int CNT_W = SLOT_W + 1;
	localparam int SUM_W = 16 + SLOT_W;
	localparam int NUM_W = SUM_W;
	localparam int DEN_W = (CNT_W > 8) ? CNT_W : 8;
	localparam int BAND_COUNT = 7;
	localparam logic [8:0] TOP_INDEX = 9'd500;

	typedef enum logic [1:0] {
		OP_STORE   = 2'd0,
		OP_QUERY   = 2'd1,
		OP_INSTANT = 2'd2
	} op_t;

	typedef struct packed {
		logic [9:0] fine_lo;
		logic [9:0] fine_hi;
		logic [9:0] coarse_lo;
		logic [9:0] coarse_hi;
		logic [9:0] idx_lo;
		logic [9:0] idx_hi;
	} band_row_t;

	// Band found for one concentration, ready for the interpolation divide.
	typedef struct packed {
		logic       hit;
		logic [7:0] diff;
		logic [6:0] rise;
		logic [7:0] span;
		logic [8:0] ilo;
	} band_sel_t;

	typedef struct packed {
		logic capture;
		logic ring_read;
		logic ring_write;
		logic div_avg;
		logic avg_take;
		logic band_load;
		logic div_idx;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} dp_stat_t;

	function automatic band_row_t band_row(input logic [2:0] b);
		band_row_t r;
		case (b)
			3'd0:    r = '{10'd0,   10'd12,  10'd0,   10'd54,  10'd0,   10'd50};
			3'd1:    r = '{10'd13,  10'd35,  10'd55,  10'd154, 10'd51,  10'd100};
			3'd2:    r = '{10'd36,  10'd55,  10'd155, 10'd254, 10'd101, 10'd150};
			3'd3:    r = '{10'd56,  10'd150, 10'd255, 10'd354, 10'd151, 10'd200};
			3'd4:    r = '{10'd151, 10'd250, 10'd355, 10'd424, 10'd201, 10'd300};
			3'd5:    r = '{10'd251, 10'd350, 10'd425, 10'd504, 10'd301, 10'd400};
			default: r = '{10'd351, 10'd500, 10'd505, 10'd604, 10'd401, 10'd500};
		endcase
		return r;
	endfunction

	// Bands are contiguous over the integers, so at most one matches.
	function automatic band_sel_t band_lookup(input logic [15:0] c, input logic coarse);
		band_sel_t s;
		band_row_t r;
		logic [15:0] lo;
		logic [15:0] hi;
		s = '0;
		for (int b = 0; b < BAND_COUNT; b++) begin
			r = band_row(3'(b));
			lo = coarse ? {6'd0, r.coarse_lo} : {6'd0, r.fine_lo};
			hi = coarse ? {6'd0, r.coarse_hi} : {6'd0, r.fine_hi};
			if (c >= lo && c <= hi) begin
				s.hit = 1'b1;
				s.diff = 8'(c - lo);
				s.rise = 7'(r.idx_hi - r.idx_lo);
				s.span = 8'(hi - lo);
				s.ilo = 9'(r.idx_lo);
			end
		end
		return s;
	endfunction

endpackage

// ===== rtl/core/raqi_in_if.sv =====
// Input channel: one word carries an operation and a PM2.5 / PM10 pair.
// Uses raqi_pkg for nothing; widths are fixed by the field definitions.
interface raqi_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] pm_fine;
	logic [15:0] pm_coarse;

	modport source (output valid, output operation, output pm_fine, output pm_coarse,
		input ready);
	modport sink (input valid, input operation, input pm_fine, input pm_coarse,
		output ready);
endinterface

// ===== rtl/core/raqi_out_if.sv =====
// Output channel: one word carries the index and the window-full flag.
// No dependencies.
interface raqi_out_if;
	logic       valid;
	logic       ready;
	logic [8:0] aqi_value;
	logic       history_full;

	modport source (output valid, output aqi_value, output history_full, input ready);
	modport sink (input valid, input aqi_value, input history_full, output ready);
endinterface

// ===== rtl/core/raqi_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on raqi_pkg for the operand widths.
module raqi_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [raqi_pkg::NUM_W-1:0]  dividend,
	input  logic [raqi_pkg::DEN_W-1:0]  divisor,
	output logic                        done,
	output logic [raqi_pkg::NUM_W-1:0]  quotient
);
	localparam int CW = $clog2(raqi_pkg::NUM_W + 1);

	logic [raqi_pkg::NUM_W-1:0] num_q;
	logic [raqi_pkg::DEN_W-1:0] den_q;
	logic [raqi_pkg::DEN_W-1:0] rem_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [raqi_pkg::DEN_W:0]   trial;
	logic                       take;

	assign trial = {rem_q, num_q[raqi_pkg::NUM_W-1]};
	assign take = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(raqi_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The quotient bits shift into num_q as the dividend bits shift out.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[raqi_pkg::NUM_W-2:0], take};
			rem_q <= take ? raqi_pkg::DEN_W'(trial - {1'b0, den_q})
				: raqi_pkg::DEN_W'(trial);
		end
	end

	assign done = done_q;
	assign quotient = num_q;
endmodule

// ===== rtl/core/raqi_dp.sv =====
// Datapath: sample ring, running sums, two divider lanes, band lookup, result register.
// Depends on raqi_pkg, raqi_div, raqi_out_if and the shared assertion macros.
`include "rolling_average_air_quality_index_defines.svh"

module raqi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  raqi_pkg::dp_cmd_t   cmd,
	output raqi_pkg::dp_stat_t  stat,
	input  logic [15:0]         pm_fine,
	input  logic [15:0]         pm_coarse,
	raqi_out_if.source          result
);
	localparam logic [raqi_pkg::SLOT_W-1:0] LAST_SLOT =
		raqi_pkg::SLOT_W'(raqi_pkg::WINDOW_SLOTS - 1);

	logic [31:0] ring_mem [raqi_pkg::WINDOW_SLOTS];
	logic [31:0] rd_q;

	logic [raqi_pkg::SLOT_W-1:0] slot_q;
	logic                        full_q;
	logic [raqi_pkg::SUM_W-1:0]  sum_fine_q;
	logic [raqi_pkg::SUM_W-1:0]  sum_coarse_q;
	logic [15:0]                 fine_q;
	logic [15:0]                 coarse_q;
	raqi_pkg::band_sel_t         band_f_q;
	raqi_pkg::band_sel_t         band_c_q;
	logic                        out_valid_q;
	logic [8:0]                  aqi_q;
	logic                        out_full_q;

	logic [raqi_pkg::CNT_W-1:0]  count;
	logic [raqi_pkg::NUM_W-1:0]  num_f;
	logic [raqi_pkg::NUM_W-1:0]  num_c;
	logic [raqi_pkg::DEN_W-1:0]  den_f;
	logic [raqi_pkg::DEN_W-1:0]  den_c;
	logic                        div_start;
	logic                        done_f;
	logic                        done_c;
	logic [raqi_pkg::NUM_W-1:0]  quo_f;
	logic [raqi_pkg::NUM_W-1:0]  quo_c;
	logic [8:0]                  sub_f;
	logic [8:0]                  sub_c;

	// Ring storage, no reset: a slot's read value is used only after the ring has wrapped.
	always_ff @(posedge clk) begin
		if (cmd.ring_read) begin
			rd_q <= ring_mem[slot_q];
		end
		if (cmd.ring_write) begin
			ring_mem[slot_q] <= {coarse_q, fine_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
			sum_fine_q <= '0;
			sum_coarse_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ring_write) begin
				sum_fine_q <= sum_fine_q + raqi_pkg::SUM_W'(fine_q)
					- (full_q ? raqi_pkg::SUM_W'(rd_q[15:0]) : '0);
				sum_coarse_q <= sum_coarse_q + raqi_pkg::SUM_W'(coarse_q)
					- (full_q ? raqi_pkg::SUM_W'(rd_q[31:16]) : '0);
				if (slot_q == LAST_SLOT) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fine_q <= pm_fine;
			coarse_q <= pm_coarse;
		end else if (cmd.avg_take) begin
			fine_q <= quo_f[15:0];
			coarse_q <= quo_c[15:0];
		end
		if (cmd.band_load) begin
			band_f_q <= raqi_pkg::band_lookup(fine_q, 1'b0);
			band_c_q <= raqi_pkg::band_lookup(coarse_q, 1'b1);
		end
		if (cmd.finish) begin
			aqi_q <= (sub_f > sub_c) ? sub_f : sub_c;
			out_full_q <= full_q;
		end
	end

	// Sample count: the whole window once wrapped, else the slots written, at least one.
	always_comb begin
		if (full_q) begin
			count = raqi_pkg::CNT_W'(raqi_pkg::WINDOW_SLOTS);
		end else if (slot_q == '0) begin
			count = raqi_pkg::CNT_W'(1);
		end else begin
			count = {1'b0, slot_q};
		end
	end

	always_comb begin
		if (cmd.div_avg) begin
			num_f = sum_fine_q;
			num_c = sum_coarse_q;
			den_f = raqi_pkg::DEN_W'(count);
			den_c = raqi_pkg::DEN_W'(count);
		end else begin
			num_f = raqi_pkg::NUM_W'({8'd0, band_f_q.rise} * {7'd0, band_f_q.diff});
			num_c = raqi_pkg::NUM_W'({8'd0, band_c_q.rise} * {7'd0, band_c_q.diff});
			den_f = raqi_pkg::DEN_W'(band_f_q.span);
			den_c = raqi_pkg::DEN_W'(band_c_q.span);
		end
	end

	assign div_start = cmd.div_avg | cmd.div_idx;

	raqi_div u_div_fine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_f),
		.divisor  (den_f),
		.done     (done_f),
		.quotient (quo_f)
	);

	raqi_div u_div_coarse (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_c),
		.divisor  (den_c),
		.done     (done_c),
		.quotient (quo_c)
	);

	assign sub_f = band_f_q.hit ? band_f_q.ilo + quo_f[8:0] : raqi_pkg::TOP_INDEX;
	assign sub_c = band_c_q.hit ? band_c_q.ilo + quo_c[8:0] : raqi_pkg::TOP_INDEX;

	assign stat.div_done = done_f;
	assign stat.out_free = !out_valid_q || result.ready;

	assign result.valid = out_valid_q;
	assign result.aqi_value = aqi_q;
	assign result.history_full = out_full_q;

	`RAQI_ASSERT_NOW(a_lanes_in_step, done_f || done_c, done_f && done_c, "divider lanes diverged")
	`RAQI_ASSERT_NEXT(a_full_sticky, full_q, full_q, "window-full flag dropped")
	`RAQI_ASSERT_NEXT(a_wrap, cmd.ring_write && slot_q == LAST_SLOT, slot_q == '0 && full_q, "ring wrap did not set full")
endmodule

// ===== rtl/core/raqi_ctrl.sv =====
// Controller state machine: sequences store, query and instant words through the datapath.
// Depends on raqi_pkg and the shared assertion macros.
`include "rolling_average_air_quality_index_defines.svh"

module raqi_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_op,
	input  raqi_pkg::dp_stat_t  stat,
	output raqi_pkg::dp_cmd_t   cmd
);
	typedef enum logic [3:0] {
		IDLE,
		ST_READ,
		ST_WRITE,
		AVG_START,
		AVG_WAIT,
		BAND,
		IDX_START,
		IDX_WAIT,
		FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == IDLE);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						unique case (in_op)
							raqi_pkg::OP_STORE:   state_q <= ST_READ;
							raqi_pkg::OP_QUERY:   state_q <= AVG_START;
							raqi_pkg::OP_INSTANT: state_q <= BAND;
							default:              state_q <= IDLE;
						endcase
					end
				end
				ST_READ:   state_q <= ST_WRITE;
				ST_WRITE:  state_q <= IDLE;
				AVG_START: state_q <= AVG_WAIT;
				AVG_WAIT: begin
					if (stat.div_done) begin
						state_q <= BAND;
					end
				end
				BAND:      state_q <= IDX_START;
				IDX_START: state_q <= IDX_WAIT;
				IDX_WAIT: begin
					if (stat.div_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (stat.out_free) begin
						state_q <= IDLE;
					end
				end
				default:   state_q <= IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.capture = accept;
		cmd.ring_read = (state_q == ST_READ);
		cmd.ring_write = (state_q == ST_WRITE);
		cmd.div_avg = (state_q == AVG_START);
		cmd.avg_take = (state_q == AVG_WAIT) && stat.div_done;
		cmd.band_load = (state_q == BAND);
		cmd.div_idx = (state_q == IDX_START);
		cmd.finish = (state_q == FINISH) && stat.out_free;
	end

	`RAQI_ASSERT_NOW(a_done_when_waiting, stat.div_done, state_q == AVG_WAIT || state_q == IDX_WAIT, "divider finished outside a wait state")
	`RAQI_ASSERT_NEXT(a_store_reads_ring, accept && in_op == raqi_pkg::OP_STORE, state_q == ST_READ, "store word did not read the ring")
	`RAQI_ASSERT_NOW(a_finish_has_room, cmd.finish, stat.out_free, "result loaded over an untaken word")
endmodule

// ===== rtl/core/rolling_average_air_quality_index.sv =====
// Top level of the rolling average air quality index block.
// Depends on raqi_pkg, raqi_in_if, raqi_out_if, raqi_ctrl, raqi_dp and raqi_div.
//
// Each input word carries an operation and a PM2.5 / PM10 pair. A store word writes
// the pair into a ring of raqi_pkg::WINDOW_SLOTS slots and updates two running sums,
// dropping the overwritten pair once the ring has wrapped; it gives no result and goes
// through a ring read, then a ring write and sum update. A query word divides both sums
// by the sample count (the window once full, otherwise the slots written, at least one)
// and an instant word uses its own pair. Each concentration is placed in one of seven
// breakpoint bands and interpolated with floor division; a value above the top band
// gives 500, and the result is the larger of the two sub-indices, together with the
// window-full flag. All divides run on two restoring dividers, one per pollutant, that
// retire one quotient bit per cycle. An instant word makes one divider pass and a query
// word two: the average divide, then the interpolation divide. Words are taken one at a
// time; the result sits in an output register, so the next word is accepted while an
// earlier result still waits to be taken. The ring is not cleared after reset: the value
// read from a slot is used only after every slot has been written.
module rolling_average_air_quality_index (
	input  logic       clk,
	input  logic       arst_n,
	raqi_in_if.sink    sample,
	raqi_out_if.source result
);
	raqi_pkg::dp_cmd_t  cmd;
	raqi_pkg::dp_stat_t stat;
	logic               in_ready;

	assign sample.ready = in_ready;

	raqi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.in_op    (sample.operation),
		.stat     (stat),
		.cmd      (cmd)
	);

	raqi_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.pm_fine   (sample.pm_fine),
		.pm_coarse (sample.pm_coarse),
		.result    (result)
	);
endmodule
